>>> src/ipv4bl_pkg.sv
// Shared types and constants of the IPv4 destination blacklist filter.
`timescale 1ns / 1ps

package ipv4bl_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int Q_DEPTH           = 2;

    localparam logic [1:0]  OP_INSERT      = 2'd0;
    localparam logic [1:0]  OP_CLEAR       = 2'd1;
    localparam logic [1:0]  OP_CHECK       = 2'd2;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Command kinds after classification by the front end.
    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_CLEAR  = 2'd1,
        K_CHECK  = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [15:0] port;
    } t_cmd;

endpackage

>>> src/ipv4bl_front.sv
// Front end: takes an item and classifies it into a command for the queue.
`timescale 1ns / 1ps

module ipv4bl_front
    import ipv4bl_pkg::*;
(
    input  logic        i_start,
    input  logic        i_full,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_rule_addr,
    input  logic [15:0] i_rule_port,
    input  logic [15:0] i_ethertype,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_dest_addr,
    input  logic [15:0] i_dest_port,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic qualify;

    // Only TCP or UDP over IPv4 ever needs a table lookup.
    assign qualify = (i_ethertype == ETHERTYPE_IPV4) &&
                     ((i_ip_protocol == PROTO_TCP) || (i_ip_protocol == PROTO_UDP));

    assign o_push = i_start && !i_full;

    always_comb begin
        o_cmd.kind = K_NOP;
        o_cmd.addr = i_dest_addr;
        o_cmd.port = i_dest_port;
        unique case (i_op)
            OP_INSERT: begin
                o_cmd.kind = K_INSERT;
                o_cmd.addr = i_rule_addr;
                o_cmd.port = i_rule_port;
            end
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
            end
            OP_CHECK: begin
                o_cmd.kind = qualify ? K_CHECK : K_NOP;
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

>>> src/ipv4bl_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ipv4bl_queue
    import ipv4bl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> src/ipv4bl_back.sv
// Back end: rule table lanes, fill count and result register.
`timescale 1ns / 1ps

module ipv4bl_back
    import ipv4bl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_cmd             i_cmd,
    output logic             o_valid,
    output logic             o_drop,
    output logic             o_status,
    output logic [CNT_W-1:0] o_rule_count
);

    logic [31:0]              r_addr [TABLE_ENTRIES];
    logic [15:0]              r_port [TABLE_ENTRIES];
    logic [CNT_W-1:0]         r_count, n_count;
    logic [TABLE_ENTRIES-1:0] hit;
    logic                     table_full;
    logic                     do_ins;
    logic                     is_chk;

    logic                     r_s1_valid;
    logic [TABLE_ENTRIES-1:0] r_s1_hit;
    logic                     r_s1_status;
    logic [CNT_W-1:0]         r_s1_count;

    // Rules fill the table from slot zero up, so slot i holds a rule iff i < count.
    assign table_full = (r_count == CNT_W'(TABLE_ENTRIES));
    assign do_ins     = i_valid && (i_cmd.kind == K_INSERT) && !table_full;
    assign is_chk     = i_valid && (i_cmd.kind == K_CHECK);

    always_comb begin
        n_count = r_count;
        if (i_valid) begin
            unique case (i_cmd.kind)
                K_INSERT: begin
                    if (!table_full) begin
                        n_count = r_count + 1'b1;
                    end
                end
                K_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (do_ins && (r_count == CNT_W'(g))) begin
                r_addr[g] <= i_cmd.addr;
                r_port[g] <= i_cmd.port;
            end
        end

        // A rule port of zero is a wildcard.
        assign hit[g] = (CNT_W'(g) < r_count) && (r_addr[g] == i_cmd.addr) &&
                        ((r_port[g] == '0) || (r_port[g] == i_cmd.port));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit    <= is_chk ? hit : '0;
        r_s1_status <= i_valid && (i_cmd.kind == K_INSERT) && table_full;
        r_s1_count  <= n_count;
    end

    assign o_valid      = r_s1_valid;
    assign o_drop       = |r_s1_hit;
    assign o_status     = r_s1_status;
    assign o_rule_count = r_s1_count;

endmodule

>>> src/ipv4_dest_blacklist_filter_top.sv
// Top level of the IPv4 destination blacklist filter.
// A result strobes on o_valid after the item passes the queue and the result register.
// Throughput: one item per cycle; the back end drains the queue every cycle, so
// busy stays low in normal use and results come out in order of acceptance.
// Reset (i_rst_n low, synchronous) empties the queue and the rule table count.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps

module ipv4_dest_blacklist_filter_top
    import ipv4bl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_op,
    input  logic [31:0]                        i_rule_addr,
    input  logic [15:0]                        i_rule_port,
    input  logic [15:0]                        i_ethertype,
    input  logic [7:0]                         i_ip_protocol,
    input  logic [31:0]                        i_dest_addr,
    input  logic [15:0]                        i_dest_port,
    output logic                               o_valid,
    output logic                               o_drop,
    output logic                               o_status,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_rule_count
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic push;
    t_cmd front_cmd;
    logic q_valid;
    logic q_full;
    t_cmd q_cmd;

    assign busy = q_full;

    ipv4bl_front u_front (
        .i_start      (start),
        .i_full       (q_full),
        .i_op         (i_op),
        .i_rule_addr  (i_rule_addr),
        .i_rule_port  (i_rule_port),
        .i_ethertype  (i_ethertype),
        .i_ip_protocol(i_ip_protocol),
        .i_dest_addr  (i_dest_addr),
        .i_dest_port  (i_dest_port),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    ipv4bl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (q_valid),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_cmd  (q_cmd)
    );

    ipv4bl_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .CNT_W        (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .o_drop      (o_drop),
        .o_status    (o_status),
        .o_rule_count(o_rule_count)
    );

    // The back end pops every cycle, so the queue never fills up.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("command queue filled up");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted item produced no result two cycles later");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rule_count <= CNT_W'(TABLE_ENTRIES)))
        else $error("rule count above table size");

    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> ((o_rule_count == CNT_W'(TABLE_ENTRIES)) && !o_drop))
        else $error("insert refused while table not full");

endmodule
